@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge while out of reset
`define LLJA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// property checked on every rising edge, reset included
`define LLJA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");
`else
`define LLJA_ASSERT(label, clk, rst_n, prop)
`define LLJA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ src/llja_pkg.sv @@
// ----------------------------------------------------------------------------
// llja_pkg
// Payload types and constants of the least-loaded job assigner
// ----------------------------------------------------------------------------
package llja_pkg;

    localparam int TIME_W   = 16;
    localparam int MASK_W   = 16;
    localparam int LOAD_W   = 32;
    localparam int MID_W    = 4;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0]  ACTIVE_RESET = CNT_W'(16);
    localparam logic [LOAD_W-1:0] LOAD_MAX     = '1;

    // one job
    typedef struct packed {
        logic [TIME_W-1:0] job_time;
        logic [MASK_W-1:0] eligible_mask;
        logic              start_batch;
    } t_job;

    // one result
    typedef struct packed {
        logic              placed;
        logic [MID_W-1:0]  assigned_machine;
        logic [LOAD_W-1:0] machine_load;
        logic [LOAD_W-1:0] makespan;
    } t_res;

    // configuration write data
    typedef struct packed {
        logic [CNT_W-1:0] active_machines;
    } t_cfg;

    // load store control from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_ram_ctl;

endpackage

@@ src/llja_chan_if.sv @@
// ----------------------------------------------------------------------------
// llja_chan_if
// Valid/ready channel carrying one payload of type T per transfer
// ----------------------------------------------------------------------------
interface llja_chan_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

@@ src/llja_load_ram.sv @@
// ----------------------------------------------------------------------------
// llja_load_ram
// Per-machine load store: one write port, one registered read port, and a
// valid bit per entry so that reset and batch start clear it at once
// ----------------------------------------------------------------------------
module llja_load_ram
    import llja_pkg::*;
#(
    parameter int MACHINES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ram_ctl                    i_ctl,
    input  logic [$clog2(MACHINES)-1:0] i_rd_addr,
    input  logic [$clog2(MACHINES)-1:0] i_wr_addr,
    input  logic [LOAD_W-1:0]           i_wr_data,
    output logic [LOAD_W-1:0]           o_rd_data
);

    logic [LOAD_W-1:0]   r_mem [MACHINES];
    logic [MACHINES-1:0] r_valid;
    logic [LOAD_W-1:0]   r_rd_data;

    // valid bits: cleared by reset and batch start, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // storage and registered read, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/llja_sequencer.sv @@
// ----------------------------------------------------------------------------
// llja_sequencer
// Scans loads one machine a cycle through a shared comparator; if one is eligible,
// adds the job time with saturation, writes the load back and updates the makespan
// ----------------------------------------------------------------------------
module llja_sequencer
    import llja_pkg::*;
#(
    parameter int MACHINES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  t_job                        i_job,
    output logic                        o_job_ready,
    input  logic [CNT_W-1:0]            i_limit,
    output t_ram_ctl                    o_ram_ctl,
    output logic [$clog2(MACHINES)-1:0] o_rd_addr,
    output logic [$clog2(MACHINES)-1:0] o_wr_addr,
    output logic [LOAD_W-1:0]           o_wr_data,
    input  logic [LOAD_W-1:0]           i_rd_data,
    output logic                        o_res_valid,
    output t_res                        o_res,
    input  logic                        i_res_ready
);

    localparam int AW = $clog2(MACHINES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADD,
        S_UPD,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [TIME_W-1:0] r_time;
    logic [MASK_W-1:0] r_mask;
    logic [CNT_W-1:0]  r_limit;
    logic [CNT_W-1:0]  r_k;
    logic              r_pend;
    logic [MID_W-1:0]  r_pend_idx;
    logic              r_found;
    logic [MID_W-1:0]  r_best_idx;
    logic [LOAD_W-1:0] r_best_load;
    logic [LOAD_W-1:0] r_new_load;
    logic [LOAD_W-1:0] r_makespan;
    logic              r_res_valid;
    t_res              r_res;

    logic              job_xfer;
    logic              rd_en;
    logic              res_load;
    logic [LOAD_W-1:0] cmp_a;
    logic [LOAD_W-1:0] cmp_b;
    logic              cmp_lt;
    logic [LOAD_W:0]   sum;

    assign job_xfer = i_job_valid && (r_state == S_IDLE);
    assign rd_en    = (r_state == S_SCAN) && (r_k < r_limit);
    assign res_load = (r_state == S_DONE) && (!r_res_valid || i_res_ready);

    // shared comparator: load scan, then makespan update
    assign cmp_a  = (r_state == S_UPD) ? r_makespan : i_rd_data;
    assign cmp_b  = (r_state == S_UPD) ? r_new_load : r_best_load;
    assign cmp_lt = cmp_a < cmp_b;

    // saturating add of the job time
    assign sum = {1'b0, r_best_load} + {{(LOAD_W + 1 - TIME_W){1'b0}}, r_time};

    // load store control
    assign o_ram_ctl.rd_en = rd_en;
    assign o_ram_ctl.wr_en = (r_state == S_UPD);
    assign o_ram_ctl.clear = job_xfer && i_job.start_batch;
    assign o_rd_addr       = AW'(r_k);
    assign o_wr_addr       = AW'(r_best_idx);
    assign o_wr_data       = r_new_load;

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_makespan  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            // output register: load a new result or drop the one taken
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (job_xfer) begin
                        r_time      <= i_job.job_time;
                        r_mask      <= i_job.eligible_mask;
                        r_limit     <= i_limit;
                        r_k         <= '0;
                        r_pend      <= 1'b0;
                        r_found     <= 1'b0;
                        r_best_idx  <= '0;
                        r_best_load <= '0;
                        if (i_job.start_batch) begin
                            r_makespan <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue the next read, compare the one that came back
                    r_pend     <= rd_en;
                    r_pend_idx <= r_k[MID_W-1:0];
                    if (rd_en) begin
                        r_k <= r_k + CNT_W'(1);
                    end
                    if (r_pend && r_mask[r_pend_idx] && (!r_found || cmp_lt)) begin
                        r_found     <= 1'b1;
                        r_best_idx  <= r_pend_idx;
                        r_best_load <= i_rd_data;
                    end
                    if (!rd_en) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (r_found) begin
                        r_new_load <= sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
                        r_state    <= S_UPD;
                    end else begin
                        r_new_load <= '0;
                        r_state    <= S_DONE;
                    end
                end
                S_UPD: begin
                    if (cmp_lt) begin
                        r_makespan <= r_new_load;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (res_load) begin
                        r_res.placed           <= r_found;
                        r_res.assigned_machine <= r_found ? r_best_idx : '0;
                        r_res.machine_load     <= r_new_load;
                        r_res.makespan         <= r_makespan;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

@@ src/least_loaded_job_assigner.sv @@
// ----------------------------------------------------------------------------
// least_loaded_job_assigner
// Greedy restricted-assignment scheduler: each job goes to the least loaded
// eligible machine, with loads and makespan kept across a batch
// ----------------------------------------------------------------------------
// Each job transfer carries a time, an eligibility mask and a batch-start
// flag; one result transfer follows per job. The loads are scanned one machine
// per cycle through a single comparator, L = min(active_machines, MACHINES, 16)
// of them; a placed job then has its load written back and the makespan
// updated, while a job with no eligible machine skips the write-back. A result
// waits while the previous result still waits on the output side. The job
// channel is not ready while a job is in work. The user is to write the active
// count register only while the block is idle; the block does not enforce it.
// A write takes effect with the next job; machines at index 16 or above are
// never chosen, and loads saturate at the full 32-bit value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module least_loaded_job_assigner
    import llja_pkg::*;
#(
    parameter int MACHINES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    llja_chan_if.sink   i_job,
    llja_chan_if.source o_res,
    llja_chan_if.sink   i_cfg
);

    localparam int AW = $clog2(MACHINES);
    localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'((MACHINES < MASK_W) ? MACHINES : MASK_W);

    logic [CNT_W-1:0]  r_active;
    logic [CNT_W-1:0]  limit;
    t_ram_ctl          ram_ctl;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [LOAD_W-1:0] wr_data;
    logic [LOAD_W-1:0] rd_data;
    t_job              job;
    t_res              res;
    t_cfg              cfg;
    logic              job_taken;
    logic              res_unplaced;
    logic              res_placed;
    logic              res_empty;

    // active machine count register
    assign i_cfg.ready = 1'b1;
    assign cfg         = i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RESET;
        end else if (i_cfg.valid) begin
            r_active <= cfg.active_machines;
        end
    end

    // machines actually scanned
    assign limit = (r_active > LIM_MAX) ? LIM_MAX : r_active;

    assign job        = i_job.data;
    assign o_res.data = res;

    llja_sequencer #(
        .MACHINES (MACHINES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (i_job.valid),
        .i_job       (job),
        .o_job_ready (i_job.ready),
        .i_limit     (limit),
        .o_ram_ctl   (ram_ctl),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data),
        .o_res_valid (o_res.valid),
        .o_res       (res),
        .i_res_ready (o_res.ready)
    );

    llja_load_ram #(
        .MACHINES (MACHINES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ram_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // terms for the checks below
    assign job_taken    = i_job.valid && i_job.ready;
    assign res_unplaced = o_res.valid && !res.placed;
    assign res_placed   = o_res.valid && res.placed;
    assign res_empty    = (res.assigned_machine == '0) && (res.machine_load == '0);

    // a job in work keeps the job channel closed
    `LLJA_ASSERT(a_busy_after_job, i_clk, i_rst_n, job_taken |=> !i_job.ready)
    // a job that was not placed reports no machine and no load
    `LLJA_ASSERT(a_unplaced_zero, i_clk, i_rst_n, res_unplaced |-> res_empty)
    // the makespan never falls below the load just reported
    `LLJA_ASSERT(a_makespan_bound, i_clk, i_rst_n, res_placed |-> (res.makespan >= res.machine_load))
    // the store is never cleared while a load is written back
    `LLJA_ASSERT_ALWAYS(a_no_clear_on_write, i_clk, !(ram_ctl.clear && ram_ctl.wr_en))

endmodule
